@@ rtl/second_chance_page_replacement_unit_assert.svh @@
// Assertion macros for the second chance page replacement unit
`ifndef SECOND_CHANCE_PAGE_REPLACEMENT_UNIT_ASSERT_SVH
`define SECOND_CHANCE_PAGE_REPLACEMENT_UNIT_ASSERT_SVH

// same-cycle implication
`define SCPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scpr check failed");

// next-cycle implication
`define SCPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scpr check failed");

`endif

@@ rtl/scpr_pkg.sv @@
// Package: sizes and controller/datapath handshake types for the replacement unit
`timescale 1ns / 1ps
`default_nettype none
package scpr_pkg;

	localparam int MAX_FRAMES  = 16;
	localparam int PAGE_BITS   = 16;
	localparam int SLOT_W      = $clog2(MAX_FRAMES);
	localparam int FRAME_CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int CFG_W       = 5;
	localparam int FAULT_W     = 32;
	localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(16);

	typedef struct packed {
		logic start;
		logic scan;
		logic take_hit;
		logic fault_prep;
		logic sweep;
		logic evict;
		logic load_out;
	} scpr_cmd_t;

	typedef struct packed {
		logic match_hit;
		logic match_end;
		logic victim;
		logic out_free;
	} scpr_sts_t;

endpackage
`default_nettype wire

@@ rtl/scpr_if.sv @@
// Channel interfaces: page references, results and the frame count write port
`timescale 1ns / 1ps
`default_nettype none
interface scpr_ref_if import scpr_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] page_number;
	logic                 last_of_run;

	modport src (output valid, page_number, last_of_run, input ready);
	modport snk (input valid, page_number, last_of_run, output ready);
	modport mon (input valid, ready, page_number, last_of_run);
endinterface

interface scpr_res_if import scpr_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [SLOT_W-1:0]    slot;
	logic                 evicted_valid;
	logic [PAGE_BITS-1:0] evicted_page;
	logic [FAULT_W-1:0]   fault_count;

	modport src (output valid, hit, slot, evicted_valid, evicted_page, fault_count,
		input ready);
	modport snk (input valid, hit, slot, evicted_valid, evicted_page, fault_count,
		output ready);
	modport mon (input valid, ready, hit, slot, evicted_valid, evicted_page, fault_count);
endinterface

interface scpr_cfg_if import scpr_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] frames_in_use;

	modport src (output valid, frames_in_use, input ready);
	modport snk (input valid, frames_in_use, output ready);
endinterface
`default_nettype wire

@@ rtl/scpr_ram.sv @@
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module scpr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/scpr_dp.sv @@
// Datapath: frame table, reference bits, clock hand, fault counter, result register
`timescale 1ns / 1ps
`default_nettype none
module scpr_dp import scpr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire scpr_cmd_t            cmd,
	output      scpr_sts_t            sts,
	input  wire logic [PAGE_BITS-1:0] page_number,
	input  wire logic                 last_of_run,
	scpr_cfg_if.snk                   cfg,
	scpr_res_if.src                   results
);
	logic [CFG_W-1:0]       frames_q;
	logic [FRAME_CNT_W-1:0] n_d, n_q;
	logic [PAGE_BITS-1:0]   page_q;
	logic                   last_q;
	logic [FRAME_CNT_W-1:0] idx_q;
	logic                   rd_vld_s1;
	logic [SLOT_W-1:0]      rd_idx_s1;
	logic [MAX_FRAMES-1:0]  valid_q, ref_q;
	logic [SLOT_W-1:0]      hand_q, hand_inc;
	logic [FAULT_W-1:0]     faults_q;
	logic                   issuing;
	logic [SLOT_W-1:0]      raddr;
	logic [PAGE_BITS-1:0]   rdata;
	logic                   ram_we;

	logic                   res_hit_q, res_ev_vld_q;
	logic [SLOT_W-1:0]      res_slot_q;
	logic [PAGE_BITS-1:0]   res_ev_page_q;

	logic                   out_vld_q, out_hit_q, out_ev_vld_q;
	logic [SLOT_W-1:0]      out_slot_q;
	logic [PAGE_BITS-1:0]   out_ev_page_q;
	logic [FAULT_W-1:0]     out_faults_q;

	assign cfg.ready = 1'b1;

	// frame count in use: 0 acts as 1, anything above the table size is clamped
	always_comb begin
		priority if (frames_q == '0) begin
			n_d = FRAME_CNT_W'(1);
		end else if (32'(frames_q) > MAX_FRAMES) begin
			n_d = FRAME_CNT_W'(MAX_FRAMES);
		end else begin
			n_d = FRAME_CNT_W'(frames_q);
		end
	end

	assign issuing  = idx_q < n_q;
	assign raddr    = cmd.sweep ? hand_q : idx_q[SLOT_W-1:0];
	assign hand_inc = ({1'b0, hand_q} + FRAME_CNT_W'(1) == n_q) ? '0 : hand_q + SLOT_W'(1);
	assign ram_we   = cmd.evict;

	scpr_ram #(
		.WIDTH (PAGE_BITS),
		.DEPTH (MAX_FRAMES)
	) u_page_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (hand_q),
		.wdata (page_q),
		.re    (cmd.scan | cmd.sweep),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign sts.match_hit = rd_vld_s1 && valid_q[rd_idx_s1] && (rdata == page_q);
	assign sts.match_end = rd_vld_s1 && ({1'b0, rd_idx_s1} + FRAME_CNT_W'(1) == n_q);
	assign sts.victim    = !ref_q[hand_q];
	assign sts.out_free  = !out_vld_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q  <= FRAMES_RESET;
			rd_vld_s1 <= 1'b0;
			valid_q   <= '0;
			ref_q     <= '0;
			hand_q    <= '0;
			faults_q  <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				frames_q <= cfg.frames_in_use;
			end
			rd_vld_s1 <= cmd.scan && issuing;
			if (cmd.take_hit) begin
				ref_q[rd_idx_s1] <= 1'b1;
			end
			if (cmd.fault_prep) begin
				if (faults_q != '1) begin
					faults_q <= faults_q + FAULT_W'(1);
				end
				if ({1'b0, hand_q} >= n_q) begin
					hand_q <= '0;
				end
			end
			if (cmd.sweep && !sts.victim) begin
				ref_q[hand_q] <= 1'b0;
				hand_q        <= hand_inc;
			end
			if (cmd.evict) begin
				valid_q[hand_q] <= 1'b1;
				ref_q[hand_q]   <= 1'b1;
				hand_q          <= hand_inc;
			end
			if (results.valid && results.ready) begin
				out_vld_q <= 1'b0;
			end
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
				if (last_q) begin
					valid_q  <= '0;
					ref_q    <= '0;
					hand_q   <= '0;
					faults_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			page_q <= page_number;
			last_q <= last_of_run;
			n_q    <= n_d;
		end
		if (cmd.start) begin
			idx_q <= '0;
		end else if (cmd.scan && issuing) begin
			idx_q <= idx_q + FRAME_CNT_W'(1);
		end
		rd_idx_s1 <= idx_q[SLOT_W-1:0];
		if (cmd.take_hit) begin
			res_hit_q     <= 1'b1;
			res_slot_q    <= rd_idx_s1;
			res_ev_vld_q  <= 1'b0;
			res_ev_page_q <= '0;
		end
		if (cmd.evict) begin
			res_hit_q     <= 1'b0;
			res_slot_q    <= hand_q;
			res_ev_vld_q  <= valid_q[hand_q];
			res_ev_page_q <= valid_q[hand_q] ? rdata : '0;
		end
		if (cmd.load_out) begin
			out_hit_q     <= res_hit_q;
			out_slot_q    <= res_slot_q;
			out_ev_vld_q  <= res_ev_vld_q;
			out_ev_page_q <= res_ev_page_q;
			out_faults_q  <= faults_q;
		end
	end

	assign results.valid         = out_vld_q;
	assign results.hit           = out_hit_q;
	assign results.slot          = out_slot_q;
	assign results.evicted_valid = out_ev_vld_q;
	assign results.evicted_page  = out_ev_page_q;
	assign results.fault_count   = out_faults_q;
endmodule
`default_nettype wire

@@ rtl/scpr_ctrl.sv @@
// Controller: sequences match scan, hand sweep, fill and result hand-off
`timescale 1ns / 1ps
`default_nettype none
module scpr_ctrl import scpr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output      logic      in_ready,
	input  wire scpr_sts_t sts,
	output      scpr_cmd_t cmd
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MATCH = 3'd1;
	localparam logic [2:0] ST_FPREP = 3'd2;
	localparam logic [2:0] ST_SWEEP = 3'd3;
	localparam logic [2:0] ST_EVICT = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_MATCH;
				end
			end
			ST_MATCH: begin
				cmd.scan = 1'b1;
				priority if (sts.match_hit) begin
					cmd.take_hit = 1'b1;
					state_d      = ST_DONE;
				end else if (sts.match_end) begin
					state_d = ST_FPREP;
				end else begin
					state_d = ST_MATCH;
				end
			end
			ST_FPREP: begin
				cmd.fault_prep = 1'b1;
				state_d        = ST_SWEEP;
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.victim) begin
					state_d = ST_EVICT;
				end
			end
			ST_EVICT: begin
				cmd.evict = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

@@ rtl/second_chance_page_replacement_unit.sv @@
// Top level: second chance (clock) page replacement unit
//
// Channels: refs takes one page reference per beat (page_number, last_of_run);
// results returns exactly one beat per reference (hit, slot, evicted_valid,
// evicted_page, fault_count); cfg writes frames_in_use and is always ready.
// Write cfg only while no reference is in flight.
// With n the frame count in use: the match scan reads one frame per cycle
// from the page RAM; a fault scans all n frames, then passes through a
// prepare state, a sweep that clears reference bits until it meets a frame
// whose bit is clear, and a fill. A new reference is taken the cycle after
// the previous one has been placed in the result register.
// Reset empties the frame table, zeroes the hand and fault count, and sets
// frames_in_use to 16. A last_of_run beat clears the same state (not the
// frame count) once its result is registered.
// A stalled results channel holds its beat; one further reference is
// worked through and then waits until the result register frees.
`timescale 1ns / 1ps
`default_nettype none
module second_chance_page_replacement_unit import scpr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	scpr_ref_if.snk  refs,
	scpr_res_if.src  results,
	scpr_cfg_if.snk  cfg
);
	scpr_cmd_t cmd;
	scpr_sts_t sts;
	logic      in_ready;

	assign refs.ready = in_ready;

	scpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (refs.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	scpr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.page_number (refs.page_number),
		.last_of_run (refs.last_of_run),
		.cfg         (cfg),
		.results     (results)
	);
endmodule
`default_nettype wire

@@ rtl/scpr_checker.sv @@
// Port-level checks for the replacement unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "second_chance_page_replacement_unit_assert.svh"
module scpr_checker import scpr_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 refs_valid,
	input wire logic                 refs_ready,
	input wire logic                 res_valid,
	input wire logic                 res_ready,
	input wire logic                 res_hit,
	input wire logic [SLOT_W-1:0]    res_slot,
	input wire logic                 res_ev_valid,
	input wire logic [PAGE_BITS-1:0] res_ev_page,
	input wire logic [FAULT_W-1:0]   res_faults
);
	`SCPR_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_slot) && $stable(res_faults))
	`SCPR_ASSERT_NOW(a_hit_no_evict, clk, arst_n, res_valid && res_hit, !res_ev_valid && res_ev_page == '0)
	`SCPR_ASSERT_NOW(a_no_evict_zero, clk, arst_n, res_valid && !res_ev_valid, res_ev_page == '0)
	`SCPR_ASSERT_NEXT(a_one_in_flight, clk, arst_n, refs_valid && refs_ready, !refs_ready)
endmodule

bind second_chance_page_replacement_unit scpr_checker u_scpr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.refs_valid   (refs.valid),
	.refs_ready   (refs.ready),
	.res_valid    (results.valid),
	.res_ready    (results.ready),
	.res_hit      (results.hit),
	.res_slot     (results.slot),
	.res_ev_valid (results.evicted_valid),
	.res_ev_page  (results.evicted_page),
	.res_faults   (results.fault_count)
);
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the second chance page replacement unit: directed rows, then random phases
`timescale 1ns / 1ps
module testbench;
	import scpr_pkg::*;

	localparam int PHASE_ITEMS = 125;
	localparam int IDLE_LIMIT  = 4000;
	localparam int DRAIN_WAIT  = 3 * MAX_FRAMES + 10;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic                 hit;
		logic [SLOT_W-1:0]    slot;
		logic                 evicted_valid;
		logic [PAGE_BITS-1:0] evicted_page;
		logic [FAULT_W-1:0]   fault_count;
	} outcome_t;

	typedef struct packed {
		logic [PAGE_BITS-1:0] page;
		logic                 last;
		logic                 typed;
		outcome_t             want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	scpr_ref_if refs();
	scpr_res_if results();
	scpr_cfg_if cfg();

	second_chance_page_replacement_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.refs   (refs),
		.results(results),
		.cfg    (cfg)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow of the frame table
	logic [CFG_W-1:0]     frames_setting;
	logic [PAGE_BITS-1:0] frame_page [MAX_FRAMES];
	logic                 frame_valid [MAX_FRAMES];
	logic                 frame_referenced [MAX_FRAMES];
	int unsigned          hand;
	logic [FAULT_W-1:0]   fault_total;

	outcome_t awaited_outcomes [$];
	int       mismatch_count;
	int       burst_left;
	int       idle_cycles;
	int       stall_left;
	logic [9:0] rx_tick;

	stim_row_t directed_rows [23] = '{
		'{16'h0000, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}},
		'{16'hFFFF, 1'b0, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 32'd2}},
		'{16'h0000, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd2}},
		'{16'hFFFF, 1'b1, 1'b1, '{1'b1, 4'd1, 1'b0, 16'h0000, 32'd2}},
		'{16'hFFFF, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}},
		'{16'h1001, 1'b0, 1'b0, '0},
		'{16'h1002, 1'b0, 1'b0, '0},
		'{16'h1003, 1'b0, 1'b0, '0},
		'{16'h1004, 1'b0, 1'b0, '0},
		'{16'h1005, 1'b0, 1'b0, '0},
		'{16'h1006, 1'b0, 1'b0, '0},
		'{16'h1007, 1'b0, 1'b0, '0},
		'{16'h1008, 1'b0, 1'b0, '0},
		'{16'h1009, 1'b0, 1'b0, '0},
		'{16'h100A, 1'b0, 1'b0, '0},
		'{16'h100B, 1'b0, 1'b0, '0},
		'{16'h100C, 1'b0, 1'b0, '0},
		'{16'h100D, 1'b0, 1'b0, '0},
		'{16'h100E, 1'b0, 1'b0, '0},
		'{16'h100F, 1'b0, 1'b0, '0},
		// table full, every bit set: the sweep goes all the way round
		'{16'h5555, 1'b0, 1'b0, '0},
		'{16'hAAAA, 1'b0, 1'b0, '0},
		'{16'h5555, 1'b1, 1'b0, '0}
	};

	logic [CFG_W-1:0] phase_frames [12] = '{
		5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd16, 5'd4, 5'd9, 5'd3, 5'd12, 5'd16, 5'd7
	};

	function automatic void clear_frames();
		for (int j = 0; j < MAX_FRAMES; j++) begin
			frame_page[j]       = '0;
			frame_valid[j]      = 1'b0;
			frame_referenced[j] = 1'b0;
		end
		hand        = 0;
		fault_total = '0;
	endfunction

	function automatic int unsigned frames_active();
		if (frames_setting == 0)
			return 1;
		if (frames_setting > MAX_FRAMES)
			return MAX_FRAMES;
		return frames_setting;
	endfunction

	function automatic outcome_t clock_reference(input logic [PAGE_BITS-1:0] page,
			input logic last);
		outcome_t    o;
		int unsigned n;
		int unsigned h;
		bit          placed;
		o      = '0;
		n      = frames_active();
		placed = 0;
		for (int j = 0; j < n; j++) begin
			if (!o.hit && frame_valid[j] && frame_page[j] == page) begin
				o.hit               = 1'b1;
				o.slot              = SLOT_W'(j);
				frame_referenced[j] = 1'b1;
			end
		end
		if (!o.hit) begin
			if (fault_total != '1)
				fault_total = fault_total + 1;
			if (hand >= n)
				hand = 0;
			while (!placed) begin
				h    = hand;
				hand = (h + 1) % n;
				if (frame_referenced[h]) begin
					frame_referenced[h] = 1'b0;
				end else begin
					if (frame_valid[h]) begin
						o.evicted_valid = 1'b1;
						o.evicted_page  = frame_page[h];
					end
					frame_page[h]       = page;
					frame_valid[h]      = 1'b1;
					frame_referenced[h] = 1'b1;
					o.slot              = SLOT_W'(h);
					placed              = 1;
				end
			end
		end
		o.fault_count = fault_total;
		if (last)
			clear_frames();
		return o;
	endfunction

	task automatic send_reference(input logic [PAGE_BITS-1:0] page, input logic last,
			input logic typed, input outcome_t want);
		int       gap;
		outcome_t predicted;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				refs.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		refs.valid       <= 1'b1;
		refs.page_number <= page;
		refs.last_of_run <= last;
		@(posedge clk);
		while (!refs.ready)
			@(posedge clk);
		predicted = clock_reference(page, last);
		awaited_outcomes.push_back(typed ? want : predicted);
	endtask

	task automatic write_frames(input logic [CFG_W-1:0] value);
		refs.valid <= 1'b0;
		wait (awaited_outcomes.size() == 0);
		@(posedge clk);
		cfg.valid         <= 1'b1;
		cfg.frames_in_use <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid      <= 1'b0;
		frames_setting  = value;
	endtask

	// receiver: random stalls, with a stall-free stretch whenever rx_tick[9:8] is zero
	always @(posedge clk) begin
		rx_tick = rx_tick + 1;
		if (rx_tick[9:8] == 2'b00) begin
			results.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			results.ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 11);
			results.ready <= 1'b0;
		end else begin
			results.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n && results.valid && results.ready) begin
			got = '{results.hit, results.slot, results.evicted_valid,
				results.evicted_page, results.fault_count};
			if (awaited_outcomes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected result beat: hit %0d slot %0d ev %0d/%h faults %0d",
						got.hit, got.slot, got.evicted_valid, got.evicted_page,
						got.fault_count);
			end else begin
				want = awaited_outcomes.pop_front();
				if (got.hit !== want.hit || got.slot !== want.slot
						|| got.evicted_valid !== want.evicted_valid
						|| got.evicted_page !== want.evicted_page
						|| got.fault_count !== want.fault_count) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("mismatch: exp hit %0d slot %0d ev %0d/%h faults %0d, got hit %0d slot %0d ev %0d/%h faults %0d",
							want.hit, want.slot, want.evicted_valid, want.evicted_page,
							want.fault_count, got.hit, got.slot, got.evicted_valid,
							got.evicted_page, got.fault_count);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((refs.valid && refs.ready) || (results.valid && results.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("second_chance_page_replacement_unit regression: fail");
			$finish;
		end
	end

	initial begin
		logic [PAGE_BITS-1:0] pool_base;
		logic [PAGE_BITS-1:0] page;
		logic                 last;
		int unsigned          n;
		clk               = 1'b0;
		arst_n            = 1'b0;
		refs.valid        = 1'b0;
		refs.page_number  = '0;
		refs.last_of_run  = 1'b0;
		results.ready     = 1'b0;
		cfg.valid         = 1'b0;
		cfg.frames_in_use = '0;
		frames_setting    = FRAMES_RESET;
		mismatch_count    = 0;
		burst_left        = 0;
		idle_cycles       = 0;
		stall_left        = 0;
		rx_tick           = '0;
		clear_frames();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_reference(directed_rows[i].page, directed_rows[i].last,
				directed_rows[i].typed, directed_rows[i].want);

		// state carries across phases, so shrinking the table hits a stale hand
		foreach (phase_frames[p]) begin
			write_frames(phase_frames[p]);
			pool_base = PAGE_BITS'($urandom);
			n         = frames_active();
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 75)
					page = pool_base + PAGE_BITS'($urandom_range(0, 2 * n));
				else
					page = PAGE_BITS'($urandom);
				last = ($urandom_range(0, 59) == 0);
				send_reference(page, last, 1'b0, '0);
			end
		end

		refs.valid <= 1'b0;
		wait (awaited_outcomes.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0 && awaited_outcomes.size() == 0)
			$display("second_chance_page_replacement_unit regression: pass");
		else
			$display("second_chance_page_replacement_unit regression: fail");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/scpr_pkg.sv
rtl/scpr_if.sv
rtl/scpr_ram.sv
rtl/scpr_dp.sv
rtl/scpr_ctrl.sv
rtl/second_chance_page_replacement_unit.sv
rtl/scpr_checker.sv
bench/testbench.sv
